// ----- rtl/omni_drive_wheel_pwm_assert.svh -----
// Assertion macros for the omni drive wheel PWM block.
`ifndef OMNI_DRIVE_WHEEL_PWM_ASSERT_SVH
`define OMNI_DRIVE_WHEEL_PWM_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock, skipped while reset is high
`define ODWP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("odwp: assertion failed");
// check a property on every clock, reset included
`define ODWP_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("odwp: reset assertion failed");
`else
`define ODWP_ASSERT(lbl, prop)
`define ODWP_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- rtl/odwp_pkg.sv -----
// Shared constants, tables and types of the omni drive wheel PWM block.
package odwp_pkg;

   localparam int SPEED_BITS      = 16;
   localparam int ANGLE_BITS      = 16;
   localparam int VEL_W           = 16;
   localparam int VEL_FRAC        = 13;
   localparam int PERIOD_W        = 16;
   localparam int HEADING_W       = 16;
   localparam int TURN_W          = 24;
   localparam int QUARTER_SHIFT   = TURN_W - 2;
   localparam int TRIG_STEPS      = 20;
   localparam int STEPS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = TRIG_STEPS / STEPS_PER_STAGE;
   localparam int TRIG_W          = 32;
   localparam int TRIG_FRAC       = 30;
   localparam int MUL_W           = VEL_W + TRIG_W;
   localparam int ROT_W           = MUL_W + 1;
   localparam int WHEEL_W         = ROT_W + 1;
   localparam int TRUNC_SHIFT     = VEL_FRAC + TRIG_FRAC - SPEED_BITS;
   localparam int TRUNC_W         = WHEEL_W - TRUNC_SHIFT;
   localparam int PROD_W          = TRUNC_W + PERIOD_W;
   localparam int DUTY_W          = PROD_W - SPEED_BITS;
   localparam int WHEELS          = 4;

   localparam logic signed [TRIG_W-1:0] TRIG_GAIN = 32'sd652032875;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

   // keep only the top ANGLE_BITS bits of the turn fraction
   localparam logic [TURN_W-1:0] ANGLE_KEEP =
      ~((TURN_W'(1) << (TURN_W - ANGLE_BITS)) - TURN_W'(1));

   // arctangent of 2^-i in 2^-24 turn units
   localparam logic signed [TURN_W-1:0] ATAN_TABLE [TRIG_STEPS] = '{
      24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050, 24'sd166669,
      24'sd83416,   24'sd41718,   24'sd20860,  24'sd10430,  24'sd5215,
      24'sd2608,    24'sd1304,    24'sd652,    24'sd326,    24'sd163,
      24'sd81,      24'sd41,      24'sd20,     24'sd10,     24'sd5
   };

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_90,
      QUAD_180,
      QUAD_270
   } quad_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] spin;
   } cmd_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [TURN_W-1:0] z;
   } rot_type;

   typedef struct packed {
      logic                     valid;
      cmd_type                  cmd;
      logic signed [TRIG_W-1:0] cos_q;
      logic signed [TRIG_W-1:0] sin_q;
   } trig_out_type;

   typedef struct packed {
      logic                              valid;
      logic [WHEELS-1:0][WHEEL_W-1:0]    speed;
   } wheel_out_type;

   typedef struct packed {
      logic                              valid;
      logic [WHEELS-1:0][PERIOD_W-1:0]   fwd;
      logic [WHEELS-1:0][PERIOD_W-1:0]   rev;
   } duty_out_type;

endpackage

// ----- rtl/odwp_cordic.sv -----
// Pipelined CORDIC: heading to cosine and sine, command carried alongside.
module odwp_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  odwp_pkg::cmd_type                   in_cmd,
   input  logic [odwp_pkg::HEADING_W-1:0]      in_heading,
   output odwp_pkg::trig_out_type              out
);

   localparam int LAST = odwp_pkg::CORDIC_STAGES - 1;

   // angle reduction stage
   logic [odwp_pkg::TURN_W-1:0]        ang;
   logic [odwp_pkg::TURN_W-1:0]        ang_round;
   logic [odwp_pkg::TURN_W-1:0]        rem;
   odwp_pkg::quad_type                 quad_in;
   logic                               v0_ff;
   odwp_pkg::cmd_type                  cmd0_ff;
   odwp_pkg::quad_type                 quad0_ff;
   logic signed [odwp_pkg::TURN_W-1:0] z0_ff;

   // rotation stages
   odwp_pkg::rot_type  rot_src [odwp_pkg::CORDIC_STAGES];
   odwp_pkg::rot_type  rot_in  [odwp_pkg::CORDIC_STAGES];
   odwp_pkg::rot_type  rot_ff  [odwp_pkg::CORDIC_STAGES];
   logic               valid_ff [odwp_pkg::CORDIC_STAGES];
   odwp_pkg::cmd_type  cmd_ff  [odwp_pkg::CORDIC_STAGES];
   odwp_pkg::quad_type quad_ff [odwp_pkg::CORDIC_STAGES];

   // quadrant fix-up stage
   logic signed [odwp_pkg::TRIG_W-1:0] cos_in;
   logic signed [odwp_pkg::TRIG_W-1:0] sin_in;
   logic                               out_valid_ff;
   odwp_pkg::cmd_type                  out_cmd_ff;
   logic signed [odwp_pkg::TRIG_W-1:0] cos_ff;
   logic signed [odwp_pkg::TRIG_W-1:0] sin_ff;

   function automatic odwp_pkg::rot_type cordic_step(input odwp_pkg::rot_type v,
                                                     input int i);
      odwp_pkg::rot_type                  r;
      logic signed [odwp_pkg::TRIG_W-1:0] xs;
      logic signed [odwp_pkg::TRIG_W-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      if (!v.z[odwp_pkg::TURN_W-1]) begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - odwp_pkg::ATAN_TABLE[i];
      end else begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + odwp_pkg::ATAN_TABLE[i];
      end
      return r;
   endfunction

   // round to the nearest quarter turn, rotate the rest
   always_comb begin
      ang       = {in_heading, {(odwp_pkg::TURN_W - odwp_pkg::HEADING_W){1'b0}}}
                  & odwp_pkg::ANGLE_KEEP;
      ang_round = ang + (odwp_pkg::TURN_W'(1) << (odwp_pkg::QUARTER_SHIFT - 1));
      quad_in   = odwp_pkg::quad_type'(ang_round[odwp_pkg::TURN_W-1 -: 2]);
      rem       = ang - {quad_in, {odwp_pkg::QUARTER_SHIFT{1'b0}}};
   end

   always_comb begin
      odwp_pkg::rot_type acc;
      rot_src[0].x = odwp_pkg::TRIG_GAIN;
      rot_src[0].y = '0;
      rot_src[0].z = z0_ff;
      for (int k = 1; k < odwp_pkg::CORDIC_STAGES; k++) begin
         rot_src[k] = rot_ff[k-1];
      end
      for (int k = 0; k < odwp_pkg::CORDIC_STAGES; k++) begin
         acc = rot_src[k];
         for (int j = 0; j < odwp_pkg::STEPS_PER_STAGE; j++) begin
            acc = cordic_step(acc, k * odwp_pkg::STEPS_PER_STAGE + j);
         end
         rot_in[k] = acc;
      end
   end

   always_comb begin
      unique case (quad_ff[LAST])
         odwp_pkg::QUAD_0: begin
            cos_in = rot_ff[LAST].x;
            sin_in = rot_ff[LAST].y;
         end
         odwp_pkg::QUAD_90: begin
            cos_in = -rot_ff[LAST].y;
            sin_in = rot_ff[LAST].x;
         end
         odwp_pkg::QUAD_180: begin
            cos_in = -rot_ff[LAST].x;
            sin_in = -rot_ff[LAST].y;
         end
         odwp_pkg::QUAD_270: begin
            cos_in = rot_ff[LAST].y;
            sin_in = -rot_ff[LAST].x;
         end
         default: begin
            cos_in = rot_ff[LAST].x;
            sin_in = rot_ff[LAST].y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < odwp_pkg::CORDIC_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v0_ff       <= in_valid;
         valid_ff[0] <= v0_ff;
         for (int k = 1; k < odwp_pkg::CORDIC_STAGES; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         out_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd0_ff  <= in_cmd;
         quad0_ff <= quad_in;
         z0_ff    <= signed'(rem);
         cmd_ff[0]  <= cmd0_ff;
         quad_ff[0] <= quad0_ff;
         for (int k = 1; k < odwp_pkg::CORDIC_STAGES; k++) begin
            cmd_ff[k]  <= cmd_ff[k-1];
            quad_ff[k] <= quad_ff[k-1];
         end
         for (int k = 0; k < odwp_pkg::CORDIC_STAGES; k++) begin
            rot_ff[k] <= rot_in[k];
         end
         out_cmd_ff <= cmd_ff[LAST];
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
      end
   end

   assign out.valid = out_valid_ff;
   assign out.cmd   = out_cmd_ff;
   assign out.cos_q = cos_ff;
   assign out.sin_q = sin_ff;

endmodule

// ----- rtl/odwp_mix.sv -----
// Heading rotation of the command and the four wheel speed sums.
module odwp_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  odwp_pkg::trig_out_type  in,
   output odwp_pkg::wheel_out_type out
);

   logic                               valid_a_ff;
   logic                               valid_b_ff;
   logic                               valid_c_ff;
   logic signed [odwp_pkg::MUL_W-1:0]  vyc_ff;
   logic signed [odwp_pkg::MUL_W-1:0]  vxs_ff;
   logic signed [odwp_pkg::MUL_W-1:0]  vxc_ff;
   logic signed [odwp_pkg::MUL_W-1:0]  vys_ff;
   logic signed [odwp_pkg::VEL_W-1:0]  spin_ff;
   logic signed [odwp_pkg::ROT_W-1:0]  rx_ff;
   logic signed [odwp_pkg::ROT_W-1:0]  ry_ff;
   logic signed [odwp_pkg::ROT_W-1:0]  r_in;
   logic signed [odwp_pkg::ROT_W-1:0]  r_ff;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::WHEEL_W-1:0] speed_in;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::WHEEL_W-1:0] speed_ff;

   // spin term in the same Q43 scale as the products
   assign r_in = odwp_pkg::ROT_W'(signed'({spin_ff, {odwp_pkg::TRIG_FRAC{1'b0}}}));

   always_comb begin
      speed_in[0] = odwp_pkg::WHEEL_W'(r_ff) + odwp_pkg::WHEEL_W'(rx_ff);
      speed_in[1] = odwp_pkg::WHEEL_W'(r_ff) + odwp_pkg::WHEEL_W'(ry_ff);
      speed_in[2] = odwp_pkg::WHEEL_W'(r_ff) - odwp_pkg::WHEEL_W'(rx_ff);
      speed_in[3] = odwp_pkg::WHEEL_W'(r_ff) - odwp_pkg::WHEEL_W'(ry_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in.valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vyc_ff   <= odwp_pkg::MUL_W'(in.cmd.vel_y) * odwp_pkg::MUL_W'(in.cos_q);
         vxs_ff   <= odwp_pkg::MUL_W'(in.cmd.vel_x) * odwp_pkg::MUL_W'(in.sin_q);
         vxc_ff   <= odwp_pkg::MUL_W'(in.cmd.vel_x) * odwp_pkg::MUL_W'(in.cos_q);
         vys_ff   <= odwp_pkg::MUL_W'(in.cmd.vel_y) * odwp_pkg::MUL_W'(in.sin_q);
         spin_ff  <= in.cmd.spin;
         rx_ff    <= odwp_pkg::ROT_W'(vyc_ff) - odwp_pkg::ROT_W'(vxs_ff);
         ry_ff    <= odwp_pkg::ROT_W'(vxc_ff) + odwp_pkg::ROT_W'(vys_ff);
         r_ff     <= r_in;
         speed_ff <= speed_in;
      end
   end

   assign out.valid = valid_c_ff;
   assign out.speed = speed_ff;

endmodule

// ----- rtl/odwp_duty.sv -----
// Wheel speed to forward and reverse PWM duty, four lanes, ends in the output register.
module odwp_duty (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [odwp_pkg::PERIOD_W-1:0]  period,
   input  odwp_pkg::wheel_out_type        in,
   output odwp_pkg::duty_out_type         out
);

   logic                                                valid_d_ff;
   logic                                                valid_e_ff;
   logic                                                valid_f_ff;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::WHEEL_W-1:0]  mag;
   logic [odwp_pkg::WHEELS-1:0]                         neg_d_ff;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::TRUNC_W-1:0]  trunc_ff;
   logic [odwp_pkg::WHEELS-1:0]                         neg_e_ff;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::PROD_W-1:0]   prod_ff;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::DUTY_W-1:0]   duty;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::PERIOD_W-1:0] sat;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::PERIOD_W-1:0] fwd_in;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::PERIOD_W-1:0] rev_in;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::PERIOD_W-1:0] fwd_ff;
   logic [odwp_pkg::WHEELS-1:0][odwp_pkg::PERIOD_W-1:0] rev_ff;

   always_comb begin
      for (int w = 0; w < odwp_pkg::WHEELS; w++) begin
         mag[w] = in.speed[w][odwp_pkg::WHEEL_W-1] ?
                  (~in.speed[w] + odwp_pkg::WHEEL_W'(1)) : in.speed[w];
      end
   end

   // drop the fraction, clamp to the period, steer to one channel
   always_comb begin
      for (int w = 0; w < odwp_pkg::WHEELS; w++) begin
         duty[w] = prod_ff[w][odwp_pkg::PROD_W-1:odwp_pkg::SPEED_BITS];
         sat[w]  = (duty[w] > odwp_pkg::DUTY_W'(period)) ?
                   period : duty[w][odwp_pkg::PERIOD_W-1:0];
         fwd_in[w] = neg_e_ff[w] ? '0 : sat[w];
         rev_in[w] = neg_e_ff[w] ? sat[w] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
         valid_f_ff <= 1'b0;
      end else if (en) begin
         valid_d_ff <= in.valid;
         valid_e_ff <= valid_d_ff;
         valid_f_ff <= valid_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_e_ff <= neg_d_ff;
         fwd_ff   <= fwd_in;
         rev_ff   <= rev_in;
         for (int w = 0; w < odwp_pkg::WHEELS; w++) begin
            neg_d_ff[w] <= in.speed[w][odwp_pkg::WHEEL_W-1];
            trunc_ff[w] <= mag[w][odwp_pkg::WHEEL_W-1:odwp_pkg::TRUNC_SHIFT];
            prod_ff[w]  <= odwp_pkg::PROD_W'(trunc_ff[w]) * odwp_pkg::PROD_W'(period);
         end
      end
   end

   assign out.valid = valid_f_ff;
   assign out.fwd   = fwd_ff;
   assign out.rev   = rev_ff;

endmodule

// ----- rtl/omni_drive_wheel_pwm.sv -----
// Omni drive wheel PWM: velocity command and heading to four wheel duty pairs.
// A request, once accepted, passes through the CORDIC registers, then the rotation/sum
// registers, then the duty registers that end in the output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset clears every valid bit and loads the PWM period register with 100.
`include "omni_drive_wheel_pwm_assert.svh"
module omni_drive_wheel_pwm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_vel_x,
   input  logic [15:0] req_vel_y,
   input  logic [15:0] req_spin,
   input  logic [15:0] req_heading,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_wheel1_fwd,
   output logic [15:0] rsp_wheel1_rev,
   output logic [15:0] rsp_wheel2_fwd,
   output logic [15:0] rsp_wheel2_rev,
   output logic [15:0] rsp_wheel3_fwd,
   output logic [15:0] rsp_wheel3_rev,
   output logic [15:0] rsp_wheel4_fwd,
   output logic [15:0] rsp_wheel4_rev,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic                           pipe_en;
   logic [odwp_pkg::PERIOD_W-1:0]  period_ff;
   odwp_pkg::cmd_type              req_cmd;
   odwp_pkg::trig_out_type         trig_out;
   odwp_pkg::wheel_out_type        wheel_out;
   odwp_pkg::duty_out_type         duty_out;

   // advance everything unless the output register is full and not taken
   assign pipe_en   = !duty_out.valid || rsp_ready;
   assign req_ready = pipe_en;
   assign csr_ready = 1'b1;

   assign req_cmd.vel_x = signed'(req_vel_x);
   assign req_cmd.vel_y = signed'(req_vel_y);
   assign req_cmd.spin  = signed'(req_spin);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= odwp_pkg::PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_data;
      end
   end

   odwp_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (req_valid),
      .in_cmd     (req_cmd),
      .in_heading (req_heading),
      .out        (trig_out)
   );

   odwp_mix u_mix (
      .clock (clock),
      .reset (reset),
      .en    (pipe_en),
      .in    (trig_out),
      .out   (wheel_out)
   );

   odwp_duty u_duty (
      .clock  (clock),
      .reset  (reset),
      .en     (pipe_en),
      .period (period_ff),
      .in     (wheel_out),
      .out    (duty_out)
   );

   assign rsp_valid      = duty_out.valid;
   assign rsp_wheel1_fwd = duty_out.fwd[0];
   assign rsp_wheel1_rev = duty_out.rev[0];
   assign rsp_wheel2_fwd = duty_out.fwd[1];
   assign rsp_wheel2_rev = duty_out.rev[1];
   assign rsp_wheel3_fwd = duty_out.fwd[2];
   assign rsp_wheel3_rev = duty_out.rev[2];
   assign rsp_wheel4_fwd = duty_out.fwd[3];
   assign rsp_wheel4_rev = duty_out.rev[3];

   `ODWP_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_valid)
   `ODWP_ASSERT(a_stall_holds_pipe, !pipe_en |=> $stable(trig_out.valid) && $stable(wheel_out.valid) && $stable(duty_out))
   `ODWP_ASSERT(a_one_channel_per_wheel, rsp_valid |-> (rsp_wheel1_fwd == 16'd0 || rsp_wheel1_rev == 16'd0) && (rsp_wheel2_fwd == 16'd0 || rsp_wheel2_rev == 16'd0) && (rsp_wheel3_fwd == 16'd0 || rsp_wheel3_rev == 16'd0) && (rsp_wheel4_fwd == 16'd0 || rsp_wheel4_rev == 16'd0))

endmodule
